### hw/rtl/bez_pkg.sv
// ----------------------------------------------------------------------------
// Cubic Bezier package
// Shared widths, types, codes and the output rounding helper for the
// de Casteljau evaluator/splitter.
// ----------------------------------------------------------------------------
package bez_pkg;

  // Base formats
  localparam int T_FRAC_BITS = 16;              // t is unsigned Q1.T_FRAC_BITS
  localparam int COORD_BITS  = 24;              // control points, signed Q.8
  localparam int T_W         = T_FRAC_BITS + 1; // t holds one exactly
  localparam int OUT_W       = COORD_BITS + 3;  // result coordinates, Q.8

  // De Casteljau level widths: a level-k value is scaled by 2^(k*T_FRAC_BITS)
  localparam int LEV_W   = COORD_BITS + 2 * T_FRAC_BITS; // widest cell input
  localparam int CELL_OW = LEV_W + T_FRAC_BITS;          // cell output
  localparam int DIFF_W  = LEV_W + 1;                    // b - a
  localparam int DLO_W   = DIFF_W / 2;                   // low part of the difference
  localparam int DHI_W   = DIFF_W - DLO_W;               // high part of the difference
  localparam int PLO_W   = T_W + DLO_W;
  localparam int PHI_W   = T_W + 1 + DHI_W;

  // Pipeline shape
  localparam int NUM_PTS     = 4;
  localparam int LEVELS      = 3;
  localparam int CELL_STAGES = 3;
  localparam int PIPE_DEPTH  = 1 + LEVELS * CELL_STAGES;
  localparam int L1_DLY      = 2 * CELL_STAGES;
  localparam int L2_DLY      = CELL_STAGES;
  localparam int DER_W       = DIFF_W + 2;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic        [T_W-1:0]        tpar_t;
  typedef logic signed [LEV_W-1:0]      lev_t;
  typedef logic signed [CELL_OW-1:0]    cell_t;
  typedef logic signed [DIFF_W-1:0]     diff_t;
  typedef logic signed [OUT_W-1:0]      out_t;
  typedef logic        [1:0]            func_t;
  typedef logic        [2:0]            idx_t;

  localparam tpar_t T_ONE = tpar_t'(1) << T_FRAC_BITS;

  // Operation selector
  localparam func_t FUNC_POINT  = 2'd0;
  localparam func_t FUNC_DERIV  = 2'd1;
  localparam func_t FUNC_SPLIT  = 2'd2;
  localparam func_t FUNC_UNUSED = 2'd3;

  // Configuration register indexes
  localparam idx_t REG_P0_X = 3'd0;
  localparam idx_t REG_P0_Y = 3'd1;
  localparam idx_t REG_P1_X = 3'd2;
  localparam idx_t REG_P1_Y = 3'd3;
  localparam idx_t REG_P2_X = 3'd4;
  localparam idx_t REG_P2_Y = 3'd5;
  localparam idx_t REG_P3_X = 3'd6;
  localparam idx_t REG_P3_Y = 3'd7;

  // Split result order
  localparam idx_t SPL_P0    = 3'd0;
  localparam idx_t SPL_L1    = 3'd1;
  localparam idx_t SPL_L2    = 3'd2;
  localparam idx_t SPL_MID_L = 3'd3;
  localparam idx_t SPL_MID_R = 3'd4;
  localparam idx_t SPL_R2    = 3'd5;
  localparam idx_t SPL_R1    = 3'd6;
  localparam idx_t SPL_P3    = 3'd7;

  // Rounded values of one axis, aligned at the pipeline tail
  typedef struct packed {
    out_t l1_lo;  // lerp(P0,P1)
    out_t l1_hi;  // lerp(P2,P3)
    out_t l2_lo;  // second level, left
    out_t l2_hi;  // second level, right
    out_t mid;    // B(t)
    out_t der;    // B'(t)
  } axis_res_t;

  // Round half up and drop sh fraction bits
  function automatic out_t round_q8(input cell_t v, input int unsigned sh);
    cell_t s;
    s = v + (cell_t'(1) << (sh - 1));
    return out_t'(s >>> sh);
  endfunction

endpackage

### hw/rtl/bez_lerp_cell.sv
// ----------------------------------------------------------------------------
// Lerp cell
// One de Casteljau step y = a*2^T + t*(b - a), exact, in three register
// stages; t travels along with the data for the next cell.
// ----------------------------------------------------------------------------
module bez_lerp_cell import bez_pkg::*; (
  input  logic  clk_i,
  input  logic  en_i,
  input  lev_t  a_i,
  input  lev_t  b_i,
  input  tpar_t t_i,
  output cell_t y_o,
  output tpar_t t_o
);

  diff_t                    d_q, d_d;
  lev_t                     a1_q, a2_q;
  tpar_t                    t1_q, t2_q, t3_q;
  logic        [PLO_W-1:0]  plo_q, plo_d;
  logic signed [PHI_W-1:0]  phi_q, phi_d;
  cell_t                    y_q, y_d;

  // stage 1: difference
  assign d_d = {b_i[LEV_W-1], b_i} - {a_i[LEV_W-1], a_i};

  // stage 2: two narrow partial products of t * d
  assign plo_d = PLO_W'(t1_q) * PLO_W'(d_q[DLO_W-1:0]);
  assign phi_d = $signed({1'b0, t1_q}) * $signed(d_q[DIFF_W-1:DLO_W]);

  // stage 3: recombine with the scaled base point
  assign y_d = {a2_q, {T_FRAC_BITS{1'b0}}}
             + {phi_q[CELL_OW-DLO_W-1:0], {DLO_W{1'b0}}}
             + {{(CELL_OW-PLO_W){1'b0}}, plo_q};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q   <= d_d;
      a1_q  <= a_i;
      t1_q  <= t_i;
      plo_q <= plo_d;
      phi_q <= phi_d;
      a2_q  <= a1_q;
      t2_q  <= t1_q;
      y_q   <= y_d;
      t3_q  <= t2_q;
    end
  end

  assign y_o = y_q;
  assign t_o = t3_q;

endmodule

### hw/rtl/bez_axis.sv
// ----------------------------------------------------------------------------
// Bezier axis
// De Casteljau triangle of lerp cells for one coordinate, with the side
// values delayed and rounded so all of them arrive at the tail together.
// ----------------------------------------------------------------------------
module bez_axis import bez_pkg::*; (
  input  logic      clk_i,
  input  logic      en_i,
  input  coord_t    p_i [NUM_PTS],
  input  tpar_t     t_i,
  output axis_res_t res_o
);

  lev_t  p_ext [NUM_PTS];
  cell_t l1 [3];
  cell_t l2 [2];
  cell_t l3;
  tpar_t t1;
  tpar_t t2;

  out_t  l1lo_q [L1_DLY];
  out_t  l1hi_q [L1_DLY];
  out_t  l2lo_q [L2_DLY];
  out_t  l2hi_q [L2_DLY];
  diff_t dd_q, dd_d;
  out_t  der0_q, der1_q, der_d;
  logic signed [DER_W-1:0] der_sum;

  // control points widened to the cell format
  always_comb begin
    for (int k = 0; k < NUM_PTS; k++) begin
      p_ext[k] = {{(LEV_W-COORD_BITS){p_i[k][COORD_BITS-1]}}, p_i[k]};
    end
  end

  // level 1
  bez_lerp_cell u_c1_0 (.clk_i, .en_i, .a_i(p_ext[0]), .b_i(p_ext[1]), .t_i,
                        .y_o(l1[0]), .t_o(t1));
  bez_lerp_cell u_c1_1 (.clk_i, .en_i, .a_i(p_ext[1]), .b_i(p_ext[2]), .t_i,
                        .y_o(l1[1]), .t_o());
  bez_lerp_cell u_c1_2 (.clk_i, .en_i, .a_i(p_ext[2]), .b_i(p_ext[3]), .t_i,
                        .y_o(l1[2]), .t_o());

  // level 2
  bez_lerp_cell u_c2_0 (.clk_i, .en_i, .a_i(l1[0][LEV_W-1:0]), .b_i(l1[1][LEV_W-1:0]),
                        .t_i(t1), .y_o(l2[0]), .t_o(t2));
  bez_lerp_cell u_c2_1 (.clk_i, .en_i, .a_i(l1[1][LEV_W-1:0]), .b_i(l1[2][LEV_W-1:0]),
                        .t_i(t1), .y_o(l2[1]), .t_o());

  // level 3
  bez_lerp_cell u_c3 (.clk_i, .en_i, .a_i(l2[0][LEV_W-1:0]), .b_i(l2[1][LEV_W-1:0]),
                      .t_i(t2), .y_o(l3), .t_o());

  // derivative: 3 * (L2 right - L2 left), rounded
  assign dd_d    = {l2[1][LEV_W-1], l2[1][LEV_W-1:0]} - {l2[0][LEV_W-1], l2[0][LEV_W-1:0]};
  assign der_sum = {{2{dd_q[DIFF_W-1]}}, dd_q} + {dd_q[DIFF_W-1], dd_q, 1'b0}
                 + (DER_W'(1) <<< (2 * T_FRAC_BITS - 1));
  assign der_d   = out_t'(der_sum >>> (2 * T_FRAC_BITS));

  // delay lines to the tail
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      l1lo_q[0] <= round_q8(l1[0], T_FRAC_BITS);
      l1hi_q[0] <= round_q8(l1[2], T_FRAC_BITS);
      for (int k = 1; k < L1_DLY; k++) begin
        l1lo_q[k] <= l1lo_q[k-1];
        l1hi_q[k] <= l1hi_q[k-1];
      end
      l2lo_q[0] <= round_q8(l2[0], 2 * T_FRAC_BITS);
      l2hi_q[0] <= round_q8(l2[1], 2 * T_FRAC_BITS);
      for (int k = 1; k < L2_DLY; k++) begin
        l2lo_q[k] <= l2lo_q[k-1];
        l2hi_q[k] <= l2hi_q[k-1];
      end
      dd_q   <= dd_d;
      der0_q <= der_d;
      der1_q <= der0_q;
    end
  end

  assign res_o.l1_lo = l1lo_q[L1_DLY-1];
  assign res_o.l1_hi = l1hi_q[L1_DLY-1];
  assign res_o.l2_lo = l2lo_q[L2_DLY-1];
  assign res_o.l2_hi = l2hi_q[L2_DLY-1];
  assign res_o.mid   = round_q8(l3, 3 * T_FRAC_BITS);
  assign res_o.der   = der1_q;

endmodule

### hw/rtl/cubic_bezier_evaluate_split.sv
// ----------------------------------------------------------------------------
// Cubic Bezier evaluate/split
// Point, derivative and de Casteljau split of a 2-D cubic Bezier curve.
// ----------------------------------------------------------------------------
// An accepted item enters a 10-stage pipeline (input register, then three
// levels of lerp cells at three stages each). Point and derivative items run
// at one item per cycle while results are accepted; a split item holds the
// single output register for eight control points, one per cycle as each is
// accepted, left curve first, last flagged on the eighth. The whole pipeline
// stalls only when its tail item cannot move into the output register. A
// selector of 3 is taken and gives no result. t above one is treated as one.
// Control points must be written only while the block is idle; not enforced.
// ----------------------------------------------------------------------------
module cubic_bezier_evaluate_split import bez_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // configuration
  input  logic                   cfg_we_i,
  input  logic [2:0]             cfg_idx_i,
  input  logic [COORD_BITS-1:0]  cfg_wdata_i,
  // input items
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [1:0]             func_i,
  input  logic [T_W-1:0]         t_param_i,
  // result items
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic signed [OUT_W-1:0] out_x_o,
  output logic signed [OUT_W-1:0] out_y_o,
  output logic [2:0]             point_index_o,
  output logic                   last_o
);

  coord_t px_q [NUM_PTS];
  coord_t py_q [NUM_PTS];

  logic [PIPE_DEPTH-1:0] pv_q;
  func_t                 pf_q [PIPE_DEPTH];
  tpar_t                 t0_q, t_sat;
  logic                  en;

  axis_res_t res_x, res_y;

  logic      ser_v_q;
  func_t     ser_func_q;
  idx_t      ser_idx_q;
  axis_res_t ser_x_q, ser_y_q;
  logic      ser_last, ser_can_load, ser_load, out_acc;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_PTS; k++) begin
        px_q[k] <= '0;
        py_q[k] <= '0;
      end
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_P0_X: px_q[0] <= cfg_wdata_i;
        REG_P0_Y: py_q[0] <= cfg_wdata_i;
        REG_P1_X: px_q[1] <= cfg_wdata_i;
        REG_P1_Y: py_q[1] <= cfg_wdata_i;
        REG_P2_X: px_q[2] <= cfg_wdata_i;
        REG_P2_Y: py_q[2] <= cfg_wdata_i;
        REG_P3_X: px_q[3] <= cfg_wdata_i;
        REG_P3_Y: py_q[3] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // global advance: hold only when the tail item has nowhere to go
  assign en         = !(pv_q[PIPE_DEPTH-1] && !ser_can_load);
  assign in_ready_o = en;

  // saturate t to one
  assign t_sat = (t_param_i > T_ONE) ? T_ONE : t_param_i;

  // item tags along the pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= '0;
    end else if (en) begin
      pv_q <= {pv_q[PIPE_DEPTH-2:0], in_valid_i && (func_i != FUNC_UNUSED)};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pf_q[0] <= func_i;
      for (int k = 1; k < PIPE_DEPTH; k++) begin
        pf_q[k] <= pf_q[k-1];
      end
      t0_q <= t_sat;
    end
  end

  // one cell triangle per axis
  bez_axis u_axis_x (.clk_i, .en_i(en), .p_i(px_q), .t_i(t0_q), .res_o(res_x));
  bez_axis u_axis_y (.clk_i, .en_i(en), .p_i(py_q), .t_i(t0_q), .res_o(res_y));

  // output register and split sequencing
  assign out_acc      = ser_v_q && out_ready_i;
  assign ser_last     = (ser_func_q != FUNC_SPLIT) || (ser_idx_q == SPL_P3);
  assign ser_can_load = !ser_v_q || (out_ready_i && ser_last);
  assign ser_load     = pv_q[PIPE_DEPTH-1] && ser_can_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ser_v_q   <= 1'b0;
      ser_idx_q <= SPL_P0;
    end else if (ser_load) begin
      ser_v_q   <= 1'b1;
      ser_idx_q <= SPL_P0;
    end else if (out_acc && ser_last) begin
      ser_v_q   <= 1'b0;
    end else if (out_acc) begin
      ser_idx_q <= ser_idx_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ser_load) begin
      ser_func_q <= pf_q[PIPE_DEPTH-1];
      ser_x_q    <= res_x;
      ser_y_q    <= res_y;
    end
  end

  // result select
  always_comb begin
    out_x_o = ser_x_q.mid;
    out_y_o = ser_y_q.mid;
    case (ser_func_q)
      FUNC_POINT: begin
        out_x_o = ser_x_q.mid;
        out_y_o = ser_y_q.mid;
      end
      FUNC_DERIV: begin
        out_x_o = ser_x_q.der;
        out_y_o = ser_y_q.der;
      end
      FUNC_SPLIT: begin
        case (ser_idx_q)
          SPL_P0: begin
            out_x_o = out_t'(px_q[0]);
            out_y_o = out_t'(py_q[0]);
          end
          SPL_L1: begin
            out_x_o = ser_x_q.l1_lo;
            out_y_o = ser_y_q.l1_lo;
          end
          SPL_L2: begin
            out_x_o = ser_x_q.l2_lo;
            out_y_o = ser_y_q.l2_lo;
          end
          SPL_MID_L, SPL_MID_R: begin
            out_x_o = ser_x_q.mid;
            out_y_o = ser_y_q.mid;
          end
          SPL_R2: begin
            out_x_o = ser_x_q.l2_hi;
            out_y_o = ser_y_q.l2_hi;
          end
          SPL_R1: begin
            out_x_o = ser_x_q.l1_hi;
            out_y_o = ser_y_q.l1_hi;
          end
          SPL_P3: begin
            out_x_o = out_t'(px_q[3]);
            out_y_o = out_t'(py_q[3]);
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  assign out_valid_o   = ser_v_q;
  assign point_index_o = ser_idx_q;
  assign last_o        = ser_last;

  // a split item ends on its final right-curve point
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o |-> (ser_func_q != FUNC_SPLIT) || (point_index_o == SPL_P3))
    else $error("split item ended early");

  // point and derivative items give one result with index zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (ser_func_q != FUNC_SPLIT) |-> last_o && (point_index_o == SPL_P0))
    else $error("single result item malformed");

  // the input side is held back only by a valid item at the tail
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> pv_q[PIPE_DEPTH-1] && ser_v_q)
    else $error("input stalled without a blocked tail item");

  // split results step through the indexes without gaps
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_o |=>
      out_valid_o && (point_index_o == $past(point_index_o) + 3'd1))
    else $error("split index skipped");

endmodule
